@@ design/pscrc_pkg.sv @@
// Shared constants, types and the byte-wise CRC-32 update for the path hash core.
// No dependencies.
`timescale 1ns / 1ps

package pscrc_pkg;

   localparam int unsigned CRC_WIDTH  = 32;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned HASH_WIDTH = 2 * CRC_WIDTH;

   localparam logic [CRC_WIDTH-1:0]  CRC_POLY   = 32'hEDB8_8320;
   localparam logic [CRC_WIDTH-1:0]  CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [BYTE_WIDTH-1:0] SLASH_BYTE = 8'h2F;

   typedef struct packed {
      logic step;
      logic last;
   } step_ctl_type;

   function automatic logic [CRC_WIDTH-1:0] crc_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [BYTE_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ design/pscrc_hash_engine.sv @@
// CRC state for the path hash: whole-prefix CRC, segment CRC and latched folder hash.
// Depends on pscrc_pkg.
`timescale 1ns / 1ps

module pscrc_hash_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  pscrc_pkg::step_ctl_type           ctl,
   input  logic [pscrc_pkg::BYTE_WIDTH-1:0]  path_byte,
   output logic [pscrc_pkg::CRC_WIDTH-1:0]   folder_hash,
   output logic [pscrc_pkg::CRC_WIDTH-1:0]   file_hash
);

   logic [pscrc_pkg::CRC_WIDTH-1:0] prefix_ff, prefix_in;
   logic [pscrc_pkg::CRC_WIDTH-1:0] segment_ff, segment_in;
   logic [pscrc_pkg::CRC_WIDTH-1:0] folder_ff, folder_in;
   logic [pscrc_pkg::CRC_WIDTH-1:0] prefix_next, segment_next, folder_next;
   logic                            is_slash;

   always_comb begin
      is_slash    = (path_byte == pscrc_pkg::SLASH_BYTE);
      prefix_next = pscrc_pkg::crc_byte(prefix_ff, path_byte);
      if (is_slash) begin
         segment_next = pscrc_pkg::CRC_INIT;
         folder_next  = ~prefix_ff;
      end else begin
         segment_next = pscrc_pkg::crc_byte(segment_ff, path_byte);
         folder_next  = folder_ff;
      end
      folder_hash = folder_next;
      file_hash   = ~segment_next;

      prefix_in  = prefix_ff;
      segment_in = segment_ff;
      folder_in  = folder_ff;
      if (ctl.step) begin
         if (ctl.last) begin
            prefix_in  = pscrc_pkg::CRC_INIT;
            segment_in = pscrc_pkg::CRC_INIT;
            folder_in  = '0;
         end else begin
            prefix_in  = prefix_next;
            segment_in = segment_next;
            folder_in  = folder_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff  <= pscrc_pkg::CRC_INIT;
         segment_ff <= pscrc_pkg::CRC_INIT;
         folder_ff  <= '0;
      end else begin
         prefix_ff  <= prefix_in;
         segment_ff <= segment_in;
         folder_ff  <= folder_in;
      end
   end

endmodule

@@ design/path_split_crc32_hash_core.sv @@
// Top level of the path hash core: input register, CRC engine, result register.
// Depends on pscrc_pkg and pscrc_hash_engine.
`timescale 1ns / 1ps
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  request  | req_valid req_ready req_path_byte             | in
//           | req_end_of_path                               |
//  response | rsp_valid rsp_ready rsp_path_hash             | out
//           | rsp_folder_hash rsp_file_hash                 |
//
//  One path byte per cycle unless a final byte waits; the CRC update is one byte-wide XOR network.
//  A result shows on rsp_valid once its final byte has passed the input register and the result register.
//  Reset clears both CRCs to all ones and the folder hash to zero.
//  A stalled result holds; bytes that do not end a path still advance behind it,
//  and a final byte waits in the input register until the result register frees.

module path_split_crc32_hash_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pscrc_pkg::BYTE_WIDTH-1:0]  req_path_byte,
   input  logic                              req_end_of_path,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pscrc_pkg::HASH_WIDTH-1:0]  rsp_path_hash,
   output logic [pscrc_pkg::CRC_WIDTH-1:0]   rsp_folder_hash,
   output logic [pscrc_pkg::CRC_WIDTH-1:0]   rsp_file_hash
);

   logic                             in_valid_ff, in_valid_in;
   logic [pscrc_pkg::BYTE_WIDTH-1:0] in_byte_ff;
   logic                             in_last_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pscrc_pkg::CRC_WIDTH-1:0]  folder_ff, file_ff;
   logic [pscrc_pkg::CRC_WIDTH-1:0]  folder_hash, file_hash;
   logic                             out_free, accept;
   pscrc_pkg::step_ctl_type          ctl;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      ctl.step    = in_valid_ff && (!in_last_ff || out_free);
      ctl.last    = in_last_ff;
      req_ready   = !in_valid_ff || ctl.step;
      accept      = req_valid && req_ready;
      in_valid_in = accept || (in_valid_ff && !ctl.step);
      if (ctl.step && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   pscrc_hash_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .path_byte   (in_byte_ff),
      .folder_hash (folder_hash),
      .file_hash   (file_hash)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_path_byte;
         in_last_ff <= req_end_of_path;
      end
      if (ctl.step && ctl.last) begin
         folder_ff <= folder_hash;
         file_ff   <= file_hash;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_folder_hash = folder_ff;
   assign rsp_file_hash   = file_ff;
   assign rsp_path_hash   = {folder_ff, file_ff};

endmodule

@@ design/pscrc_checker.sv @@
// Port-level checks for the path hash core, bound to the top level.
// Depends on pscrc_pkg and path_split_crc32_hash_core.
`timescale 1ns / 1ps

module pscrc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pscrc_pkg::HASH_WIDTH-1:0]  rsp_path_hash,
   input logic [pscrc_pkg::CRC_WIDTH-1:0]   rsp_folder_hash,
   input logic [pscrc_pkg::CRC_WIDTH-1:0]   rsp_file_hash
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hash_halves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_path_hash[63:32] == rsp_folder_hash)
                 && (rsp_path_hash[31:0] == rsp_file_hash))
      else $error("path hash halves differ from folder and file hash");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_hash))
      else $error("stalled item dropped or changed");

   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid |=> req_ready)
      else $error("request side blocked with nothing in flight");

endmodule

bind path_split_crc32_hash_core pscrc_checker u_pscrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_path_hash   (rsp_path_hash),
   .rsp_folder_hash (rsp_folder_hash),
   .rsp_file_hash   (rsp_file_hash)
);
